// ===== src/mma_pkg.sv =====
package mma_pkg;

   localparam int SAMPLE_W = 12;
   localparam int NUM_CH   = 3;
   localparam int WORD_W   = SAMPLE_W * NUM_CH;
   localparam int SEL_W    = 2;

   localparam logic [SAMPLE_W-1:0] AVG_MAX = {SAMPLE_W{1'b1}};

   // channel codes of avg_channel
   localparam logic [SEL_W-1:0] SEL_CH0 = 2'd0;
   localparam logic [SEL_W-1:0] SEL_CH1 = 2'd1;
   localparam logic [SEL_W-1:0] SEL_CH2 = 2'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_ch0;
      logic [SAMPLE_W-1:0] sample_ch1;
      logic [SAMPLE_W-1:0] sample_ch2;
      logic [SEL_W-1:0]    avg_channel;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] avg_ch0;
      logic [SAMPLE_W-1:0] avg_ch1;
      logic [SAMPLE_W-1:0] avg_ch2;
      logic [SAMPLE_W-1:0] selected_avg;
   } rsp_type;

   // control from the pipeline to the sum unit
   typedef struct packed {
      logic             update;
      logic             old_valid;
      logic [SEL_W-1:0] sel;
   } sum_ctl_type;

endpackage

// ===== src/mma_ram.sv =====
module mma_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-before-write on a shared address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mma_sum_unit.sv =====
module mma_sum_unit #(
   parameter int DEPTH     = 16,
   parameter int AVG_SHIFT = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mma_pkg::sum_ctl_type  ctl,
   input  logic [mma_pkg::WORD_W-1:0] new_word,
   input  logic [mma_pkg::WORD_W-1:0] old_word,
   output mma_pkg::rsp_type      avg
);
   import mma_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);

   logic [SUM_W-1:0]    sum_ff  [NUM_CH];
   logic [SUM_W-1:0]    sum_in  [NUM_CH];
   logic [SUM_W-1:0]    shifted [NUM_CH];
   logic [SAMPLE_W-1:0] ch_avg  [NUM_CH];
   logic [SAMPLE_W-1:0] old_s   [NUM_CH];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         // slot never written since reset reads as zero
         old_s[c]   = ctl.old_valid ? old_word[c*SAMPLE_W +: SAMPLE_W] : '0;
         sum_in[c]  = sum_ff[c] - SUM_W'(old_s[c])
                      + SUM_W'(new_word[c*SAMPLE_W +: SAMPLE_W]);
         shifted[c] = sum_in[c] >> AVG_SHIFT;
         ch_avg[c]  = (shifted[c] > SUM_W'(AVG_MAX)) ? AVG_MAX
                                                      : shifted[c][SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= '0;
         end
      end else if (ctl.update) begin
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= sum_in[c];
         end
      end
   end

   always_comb begin
      avg.avg_ch0 = ch_avg[0];
      avg.avg_ch1 = ch_avg[1];
      avg.avg_ch2 = ch_avg[2];
      case (ctl.sel)
         SEL_CH0: avg.selected_avg = ch_avg[0];
         SEL_CH1: avg.selected_avg = ch_avg[1];
         SEL_CH2: avg.selected_avg = ch_avg[2];
         default: avg.selected_avg = '0;
      endcase
   end

endmodule

// ===== src/multichannel_moving_average.sv =====
// Three-channel boxcar moving average over converter scans.
// Request channel (req_): one item per scan, three 12-bit samples and the
// channel number whose average goes to selected_avg (code 3 gives zero).
// Response channel (rsp_): one item per request, the window average of each
// channel after that scan and the selected one, saturated at 4095.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low.
// An accepted item passes through the read stage and then the response
// register. Throughput: one item per cycle while req_stall is low; the oldest
// samples are read and the new ones written at the same slot on the accepting
// edge, while the sum stage finishes the previous item.
// Samples live in one DEPTH x 36 memory, one row per write slot. Running sums
// are kept in flops and updated with new minus oldest sample.
// Reset: sums and write slot clear at once; until the slot first wraps, the
// oldest sample reads as zero, so no clearing pass is needed.
// Receiver stall: the response register holds; one more item is taken into
// the read stage, after which req_stall rises until the response drains.
module multichannel_moving_average #(
   parameter int DEPTH     = 16,
   parameter int AVG_SHIFT = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mma_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mma_pkg::rsp_type rsp_data
);
   import mma_pkg::*;

   localparam int SLOT_W = $clog2(DEPTH);

   // write slot and wrap flag
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              wrapped_ff, wrapped_in;

   // read stage: item waiting for its oldest samples
   logic              s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0] s1_word_ff;
   logic [SEL_W-1:0]  s1_sel_ff;
   logic              s1_old_valid_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic              accept;
   logic              advance;
   logic [WORD_W-1:0] req_word;
   logic [WORD_W-1:0] old_word;
   sum_ctl_type       ctl;
   rsp_type           avg;

   assign req_word = {req_data.sample_ch2, req_data.sample_ch1, req_data.sample_ch0};

   // read stage moves on when the response register is free or being taken
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // oldest samples read and new ones written at the same slot
   mma_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_word),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (old_word)
   );

   assign ctl.update    = advance;
   assign ctl.old_valid = s1_old_valid_ff;
   assign ctl.sel       = s1_sel_ff;

   mma_sum_unit #(
      .DEPTH     (DEPTH),
      .AVG_SHIFT (AVG_SHIFT)
   ) u_sum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .new_word (s1_word_ff),
      .old_word (old_word),
      .avg      (avg)
   );

   always_comb begin
      slot_in    = slot_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (slot_ff == SLOT_W'(DEPTH - 1)) begin
            slot_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         wrapped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         wrapped_ff   <= wrapped_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff      <= req_word;
         s1_sel_ff       <= req_data.avg_channel;
         s1_old_valid_ff <= wrapped_ff;
      end
      if (advance) begin
         rsp_ff <= avg;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
